// ===== rtl/mrsp_pkg.sv =====
package mrsp_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_VERSION,
    PH_COUNT_HEAD,
    PH_COUNT_BODY,
    PH_LEN_HEAD,
    PH_LEN_BODY,
    PH_TX,
    PH_TIME,
    PH_FEE,
    PH_HEIGHT,
    PH_TRAIL,
    PH_HALT
  } phase_t;

  localparam logic [2:0] KIND_TX     = 3'd0;
  localparam logic [2:0] KIND_TIME   = 3'd1;
  localparam logic [2:0] KIND_FEE    = 3'd2;
  localparam logic [2:0] KIND_HEIGHT = 3'd3;
  localparam logic [2:0] KIND_COUNT  = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;
  localparam logic [2:0] KIND_DONE   = 3'd6;

  localparam logic [1:0] ERR_MAGIC   = 2'd0;
  localparam logic [1:0] ERR_VERSION = 2'd1;
  localparam logic [1:0] ERR_COUNT   = 2'd2;
  localparam logic [1:0] ERR_TRUNC   = 2'd3;
  localparam logic [1:0] ERR_NONE    = 2'd0;

  localparam logic [1:0] REG_MAGIC       = 2'd0;
  localparam logic [1:0] REG_VERSION     = 2'd1;
  localparam logic [1:0] REG_MAX_ENTRIES = 2'd2;

  localparam logic [7:0] CS_PREFIX16 = 8'hfd;
  localparam logic [7:0] CS_PREFIX32 = 8'hfe;

  localparam logic [63:0] MAGIC_RESET       = 64'h564C4F4F504D454D;
  localparam logic [31:0] VERSION_RESET     = 32'd1;
  localparam logic [31:0] MAX_ENTRIES_RESET = 32'd100000;

  typedef struct packed {
    logic [63:0] magic_word;
    logic [31:0] expected_version;
    logic [31:0] max_entries;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [31:0] entry_index;
    logic [1:0]  error_code;
    logic        end_of_tx;
  } result_t;

  // results caused by one byte: r0 always, r1 when two is set
  typedef struct packed {
    logic    two;
    result_t r1;
    result_t r0;
  } packet_t;

endpackage

// ===== rtl/mrsp_in_if.sv =====
interface mrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, file_byte, end_of_file, input ready);
  modport sink (input valid, file_byte, end_of_file, output ready);
endinterface

// ===== rtl/mrsp_out_if.sv =====
interface mrsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] value;
  logic [31:0] entry_index;
  logic [1:0]  error_code;
  logic        end_of_tx;
  logic        last_of_run;

  modport source (output valid, kind, value, entry_index, error_code, end_of_tx,
                  last_of_run, input ready);
  modport sink (input valid, kind, value, entry_index, error_code, end_of_tx,
                last_of_run, output ready);
endinterface

// ===== rtl/mrsp_front.sv =====
module mrsp_front (
  input  logic             clk,
  input  logic             rst_n,
  mrsp_in_if.sink          in_ch,
  input  mrsp_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             push,
  output mrsp_pkg::packet_t push_data
);
  import mrsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  vw_r, vw_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] num_r, num_nxt;
  logic [63:0] left_r, left_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [3:0]  pos_inc;
  logic [63:0] acc_col;
  logic [7:0]  want;
  logic [63:0] left_dec;
  logic        cnt_fin, len_fin;
  logic [63:0] fin_val;
  logic [31:0] height_num;
  logic [1:0]  n_c;
  result_t     res_c [2];

  function automatic result_t mk(logic [2:0] k, logic [63:0] v, logic [31:0] idx,
                                 logic [1:0] e, logic eot);
    result_t r;
    r.kind        = k;
    r.value       = v;
    r.entry_index = idx;
    r.error_code  = e;
    r.end_of_tx   = eot;
    return r;
  endfunction

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;
  assign b        = in_ch.file_byte;
  assign pos_inc  = pos_r + 4'd1;
  assign acc_col  = acc_r | (64'(b) << {pos_r[2:0], 3'b000});
  assign want     = 8'(cfg.magic_word >> {pos_r[2:0], 3'b000});
  assign left_dec = left_r - 64'd1;
  assign height_num = num_r + 32'd1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    vw_nxt    = vw_r;
    total_nxt = total_r;
    num_nxt   = num_r;
    left_nxt  = left_r;
    cnt_fin   = 1'b0;
    len_fin   = 1'b0;
    fin_val   = acc_col;
    n_c       = 2'd0;
    res_c[0]  = '0;
    res_c[1]  = '0;

    case (phase_r)
      PH_MAGIC: begin
        if (b != want) begin
          res_c[n_c[0]] = mk(KIND_ERROR, 64'd0, num_nxt, ERR_MAGIC, 1'b0);
          n_c = n_c + 2'd1;
          phase_nxt = PH_HALT;
        end else begin
          pos_nxt = pos_inc;
          if (pos_inc >= 4'd8) begin
            phase_nxt = PH_VERSION;
            pos_nxt   = '0;
            acc_nxt   = '0;
          end
        end
      end
      PH_VERSION: begin
        acc_nxt = acc_col;
        pos_nxt = pos_inc;
        if (pos_inc >= 4'd4) begin
          if (acc_col[31:0] != cfg.expected_version) begin
            res_c[n_c[0]] = mk(KIND_ERROR, 64'd0, num_nxt, ERR_VERSION, 1'b0);
            n_c = n_c + 2'd1;
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt = PH_COUNT_HEAD;
          end
        end
      end
      PH_COUNT_HEAD, PH_LEN_HEAD: begin
        if (b < CS_PREFIX16) begin
          acc_nxt = 64'(b);
          fin_val = 64'(b);
          cnt_fin = (phase_r == PH_COUNT_HEAD);
          len_fin = (phase_r == PH_LEN_HEAD);
        end else begin
          vw_nxt    = (b == CS_PREFIX16) ? 4'd2 : ((b == CS_PREFIX32) ? 4'd4 : 4'd8);
          phase_nxt = (phase_r == PH_COUNT_HEAD) ? PH_COUNT_BODY : PH_LEN_BODY;
          pos_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      PH_COUNT_BODY, PH_LEN_BODY: begin
        acc_nxt = acc_col;
        pos_nxt = pos_inc;
        if (pos_inc >= vw_r) begin
          cnt_fin = (phase_r == PH_COUNT_BODY);
          len_fin = (phase_r == PH_LEN_BODY);
        end
      end
      PH_TX: begin
        left_nxt = left_dec;
        res_c[n_c[0]] = mk(KIND_TX, 64'(b), num_nxt, ERR_NONE, left_dec == '0);
        n_c = n_c + 2'd1;
        if (left_dec == '0) begin
          phase_nxt = PH_TIME;
          pos_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      PH_TIME, PH_FEE: begin
        acc_nxt = acc_col;
        pos_nxt = pos_inc;
        if (pos_inc >= 4'd8) begin
          res_c[n_c[0]] = mk((phase_r == PH_TIME) ? KIND_TIME : KIND_FEE, acc_col,
                             num_nxt, ERR_NONE, 1'b0);
          n_c = n_c + 2'd1;
          phase_nxt = (phase_r == PH_TIME) ? PH_FEE : PH_HEIGHT;
          pos_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      PH_HEIGHT: begin
        acc_nxt = acc_col;
        pos_nxt = pos_inc;
        if (pos_inc >= 4'd4) begin
          res_c[n_c[0]] = mk(KIND_HEIGHT, {32'd0, acc_col[31:0]}, num_nxt, ERR_NONE, 1'b0);
          n_c = n_c + 2'd1;
          num_nxt = height_num;
          if (height_num == total_r) begin
            res_c[n_c[0]] = mk(KIND_DONE, 64'(total_r), num_nxt, ERR_NONE, 1'b0);
            n_c = n_c + 2'd1;
            phase_nxt = PH_TRAIL;
          end else begin
            phase_nxt = PH_LEN_HEAD;
          end
        end
      end
      default: begin
      end
    endcase

    // a completed entry count
    if (cnt_fin) begin
      if (fin_val > 64'(cfg.max_entries)) begin
        res_c[n_c[0]] = mk(KIND_ERROR, 64'd0, num_nxt, ERR_COUNT, 1'b0);
        n_c = n_c + 2'd1;
        phase_nxt = PH_HALT;
      end else begin
        total_nxt = fin_val[31:0];
        res_c[n_c[0]] = mk(KIND_COUNT, fin_val, num_nxt, ERR_NONE, 1'b0);
        n_c = n_c + 2'd1;
        if (fin_val == '0) begin
          res_c[n_c[0]] = mk(KIND_DONE, 64'd0, num_nxt, ERR_NONE, 1'b0);
          n_c = n_c + 2'd1;
          phase_nxt = PH_TRAIL;
        end else begin
          phase_nxt = PH_LEN_HEAD;
        end
      end
    end

    // a completed tx length
    if (len_fin) begin
      left_nxt = fin_val;
      if (fin_val == '0) begin
        phase_nxt = PH_TIME;
        pos_nxt   = '0;
        acc_nxt   = '0;
      end else begin
        phase_nxt = PH_TX;
      end
    end

    if (in_ch.end_of_file) begin
      if (phase_nxt == PH_MAGIC) begin
        res_c[n_c[0]] = mk(KIND_ERROR, 64'd0, num_nxt, ERR_MAGIC, 1'b0);
        n_c = n_c + 2'd1;
      end else if (phase_nxt != PH_TRAIL && phase_nxt != PH_HALT) begin
        res_c[n_c[0]] = mk(KIND_ERROR, 64'd0, num_nxt, ERR_TRUNC, 1'b0);
        n_c = n_c + 2'd1;
      end
      // next byte starts a new file
      phase_nxt = PH_MAGIC;
      pos_nxt   = '0;
      acc_nxt   = '0;
      vw_nxt    = '0;
      total_nxt = '0;
      num_nxt   = '0;
      left_nxt  = '0;
    end
  end

  assign push          = accept && (n_c != 2'd0);
  assign push_data.two = n_c[1];
  assign push_data.r0  = res_c[0];
  assign push_data.r1  = res_c[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      pos_r   <= '0;
      acc_r   <= '0;
      vw_r    <= '0;
      total_r <= '0;
      num_r   <= '0;
      left_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      vw_r    <= vw_nxt;
      total_r <= total_nxt;
      num_r   <= num_nxt;
      left_r  <= left_nxt;
    end
  end

  a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_file) |=> (phase_r == PH_MAGIC && num_r == '0 && pos_r == '0))
    else $error("end of file did not return the parser to the start");

  a_two_results_max: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (n_c <= 2'd2))
    else $error("more than two results from one byte");

  a_tx_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TX) |-> (left_r != '0))
    else $error("tx phase with no bytes left");

endmodule

// ===== rtl/mrsp_queue.sv =====
module mrsp_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mrsp_pkg::packet_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output mrsp_pkg::packet_t head
);
  import mrsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  packet_t            slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue written while full");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

// ===== rtl/mrsp_back.sv =====
module mrsp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  mrsp_pkg::packet_t q_head,
  output logic              q_pop,
  mrsp_out_if.source        out_ch
);
  import mrsp_pkg::*;

  logic    sel_r, sel_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t res_r;
  logic    last_r;
  logic    load;
  logic    last_c;
  result_t pick;

  assign load   = q_valid && (!out_valid_r || out_ch.ready);
  assign last_c = sel_r || !q_head.two;
  assign pick   = sel_r ? q_head.r1 : q_head.r0;

  always_comb begin
    q_pop         = load && last_c;
    sel_nxt       = load ? !last_c : sel_r;
    out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= pick;
      last_r <= last_c;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = res_r.kind;
  assign out_ch.value       = res_r.value;
  assign out_ch.entry_index = res_r.entry_index;
  assign out_ch.error_code  = res_r.error_code;
  assign out_ch.end_of_tx   = res_r.end_of_tx;
  assign out_ch.last_of_run = last_r;

endmodule

// ===== rtl/mempool_record_stream_parser_unit.sv =====
// Parses a persisted transaction-pool file fed one byte per item (end_of_file
// flags the last byte): magic word, version, CompactSize entry count, then per
// entry a CompactSize length, the tx bytes, arrival time, fee and height. The
// input takes one byte per cycle; a byte that yields two results (count and
// done, height and done, or a result followed by an error) takes the output
// register once per result, and a queue of QUEUE_DEPTH byte-runs between the
// parser and the output stage soaks these up, so the input stalls only when
// that queue fills. Results pass a queue slot, then the output register. After
// an error the consumer drops the whole file; a flagged last byte restarts the
// parser with registers kept. Register writes take effect in the next cycle.
module mempool_record_stream_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  mrsp_in_if.sink     in_ch,
  mrsp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import mrsp_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    q_full;
  logic    push;
  packet_t push_data;
  logic    q_pop;
  logic    q_valid;
  packet_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MAGIC:       cfg_nxt.magic_word       = cfg_wdata;
        REG_VERSION:     cfg_nxt.expected_version = cfg_wdata[31:0];
        REG_MAX_ENTRIES: cfg_nxt.max_entries      = cfg_wdata[31:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word       <= MAGIC_RESET;
      cfg_r.expected_version <= VERSION_RESET;
      cfg_r.max_entries      <= MAX_ENTRIES_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mrsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  mrsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  mrsp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
